[rtl/core/stunrc_pkg.sv]
// ----------------------------------------------------------------------------
// stunrc_pkg
// Types and constants shared by the receive classifier.
// ----------------------------------------------------------------------------
package stunrc_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAY,
    ST_CRC,
    ST_RESP,
    ST_STAT
  } state_e;

  localparam logic [1:0] KIND_PAYLOAD  = 2'd0;
  localparam logic [1:0] KIND_RESPONSE = 2'd1;
  localparam logic [1:0] KIND_STATUS   = 2'd2;

  localparam logic [2:0] STS_PAYLOAD   = 3'd0;
  localparam logic [2:0] STS_RESPONSE  = 3'd1;
  localparam logic [2:0] STS_IGNORED   = 3'd2;
  localparam logic [2:0] STS_BAD_MAGIC = 3'd3;
  localparam logic [2:0] STS_MALFORMED = 3'd4;

  localparam logic [2:0] REG_MAGIC    = 3'd0;
  localparam logic [2:0] REG_BREQ     = 3'd1;
  localparam logic [2:0] REG_BRESP    = 3'd2;
  localparam logic [2:0] REG_DIND     = 3'd3;
  localparam logic [2:0] REG_DATTR    = 3'd4;
  localparam logic [2:0] REG_MAPATTR  = 3'd5;
  localparam logic [2:0] REG_FPATTR   = 3'd6;

  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] FP_XOR   = 32'h5354_554E;

  localparam logic [5:0] RESP_LAST  = 6'd39;
  localparam logic [7:0] CRC_LAST   = 8'd255;
  localparam logic [11:0] POS_MAX   = 12'd4095;

endpackage

[rtl/core/stun_receive_classify_unwrap_core.sv]
// ----------------------------------------------------------------------------
// stun_receive_classify_unwrap_core
// Classifies received packets byte by byte, streams indication payload and
// answers binding requests with a fingerprinted success response.
// ----------------------------------------------------------------------------
// One packet byte is taken per request while the block is idle. A byte that
// yields a payload byte holds off the input until that byte is taken. The
// final byte of a binding request starts a bit-serial CRC-32 over the 32
// header and address bytes (one bit per cycle in a single shift/XOR unit),
// then 40 response bytes leave one per cycle while out_ready_i is high, then
// the status. Every final byte ends with one status item.
module stun_receive_classify_unwrap_core #(
  parameter int MAX_PACKET_BYTES = 2048
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic [11:0] packet_length_i,
  input  logic        first_byte_i,
  input  logic        final_byte_i,
  input  logic [31:0] sender_ip_i,
  input  logic [15:0] sender_port_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  item_kind_o,
  output logic [7:0]  out_byte_o,
  output logic        last_of_run_o,
  output logic [2:0]  status_o,
  output logic [11:0] payload_count_o
);
  import stunrc_pkg::*;

  localparam logic [16:0] MaxLen = 17'(MAX_PACKET_BYTES);

  logic [31:0] magic_q;
  logic [15:0] breq_q, bresp_q, dind_q, dattr_q, mapattr_q, fpattr_q;

  state_e state_q, state_d;
  logic [11:0] bp_q, bp_c, bp_n;
  logic [15:0] mt_q, mt_c, mt_n, ml_q, ml_c, ml_n;
  logic [15:0] ak_q, ak_c, ak_n, pl_q, pl_c, pl_n;
  logic        cm_q, cm_c, cm_n;
  logic [7:0]  tid_q [12];
  logic [31:0] crc_q, crc_d, crc_in;
  logic [7:0]  cnt_q, cnt_d;
  logic [7:0]  pay_byte_q;
  logic        fin_q, resp_q;
  logic [2:0]  verdict_q, verdict_n;
  logic [11:0] count_q, count_n;
  logic [15:0] xport_q;
  logic [31:0] xip_q;

  logic        accept, emit, acc_c, acc_n, resp_n, tid_we;
  logic [11:0] leff, rcv, p;
  logic [3:0]  tid_wa;
  logic [7:0]  cbyte, rbyte;
  logic [5:0]  ridx;
  logic [31:0] fp;

  assign accept = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magic_q   <= 32'h2112_A442;
      breq_q    <= 16'h0001;
      bresp_q   <= 16'h0101;
      dind_q    <= 16'h0117;
      dattr_q   <= 16'h0013;
      mapattr_q <= 16'h0020;
      fpattr_q  <= 16'h8028;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_MAGIC:   magic_q   <= cfg_wdata_i;
        REG_BREQ:    breq_q    <= cfg_wdata_i[15:0];
        REG_BRESP:   bresp_q   <= cfg_wdata_i[15:0];
        REG_DIND:    dind_q    <= cfg_wdata_i[15:0];
        REG_DATTR:   dattr_q   <= cfg_wdata_i[15:0];
        REG_MAPATTR: mapattr_q <= cfg_wdata_i[15:0];
        REG_FPATTR:  fpattr_q  <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  // per-byte parse
  always_comb begin
    bp_c = first_byte_i ? '0 : bp_q;
    mt_c = first_byte_i ? '0 : mt_q;
    ml_c = first_byte_i ? '0 : ml_q;
    ak_c = first_byte_i ? '0 : ak_q;
    pl_c = first_byte_i ? '0 : pl_q;
    cm_c = first_byte_i ? 1'b1 : cm_q;
    leff = ({5'd0, packet_length_i} < MaxLen) ? packet_length_i : MaxLen[11:0];
    p = bp_c;
    mt_n = mt_c;
    ml_n = ml_c;
    ak_n = ak_c;
    pl_n = pl_c;
    cm_n = cm_c;
    tid_we = 1'b0;
    tid_wa = 4'(p - 12'd8);
    cbyte = magic_q[{~p[1:0], 3'b000} +: 8];
    if (p < leff) begin
      priority if (p < 12'd2) begin
        mt_n = {mt_c[7:0], data_byte_i};
      end else if (p < 12'd4) begin
        ml_n = {ml_c[7:0], data_byte_i};
      end else if (p < 12'd8) begin
        if (cbyte != data_byte_i) cm_n = 1'b0;
      end else if (p < 12'd20) begin
        tid_we = 1'b1;
      end else if (p < 12'd22) begin
        ak_n = {ak_c[7:0], data_byte_i};
      end else if (p < 12'd24) begin
        pl_n = {pl_c[7:0], data_byte_i};
      end else begin
      end
    end
    acc_c = cm_c && (mt_c == dind_q) && ({1'b0, ml_c} + 17'd20 <= {5'd0, leff}) &&
            (ak_c == dattr_q) && ({1'b0, pl_c} + 17'd24 <= {5'd0, leff});
    acc_n = cm_n && (mt_n == dind_q) && ({1'b0, ml_n} + 17'd20 <= {5'd0, leff}) &&
            (ak_n == dattr_q) && ({1'b0, pl_n} + 17'd24 <= {5'd0, leff});
    emit = (p < leff) && (p >= 12'd24) && acc_c && ({4'd0, p - 12'd24} < pl_c);
    bp_n = (bp_c < POS_MAX) ? bp_c + 12'd1 : bp_c;
    rcv = (bp_n < leff) ? bp_n : leff;
    resp_n = 1'b0;
    count_n = '0;
    priority if (rcv < 12'd8 || !cm_n) begin
      verdict_n = STS_BAD_MAGIC;
    end else if (mt_n == breq_q) begin
      if (rcv < 12'd20) begin
        verdict_n = STS_BAD_MAGIC;
      end else begin
        verdict_n = STS_RESPONSE;
        resp_n = 1'b1;
      end
    end else if (mt_n == bresp_q) begin
      verdict_n = STS_IGNORED;
    end else if (mt_n == dind_q) begin
      if (acc_n) begin
        verdict_n = STS_PAYLOAD;
        if (rcv > 12'd24) begin
          count_n = ({4'd0, rcv - 12'd24} < pl_n) ? rcv - 12'd24 : pl_n[11:0];
        end
      end else begin
        verdict_n = STS_MALFORMED;
      end
    end else begin
      verdict_n = STS_IGNORED;
    end
  end

  // response byte generator
  assign ridx = (state_q == ST_CRC) ? {1'b0, cnt_q[7:3]} : cnt_q[5:0];
  assign fp = ~crc_q ^ FP_XOR;

  always_comb begin
    rbyte = 8'd0;
    if (ridx >= 6'd8 && ridx < 6'd20) begin
      rbyte = tid_q[4'(ridx - 6'd8)];
    end else begin
      unique case (ridx)
        6'd0:  rbyte = bresp_q[15:8];
        6'd1:  rbyte = bresp_q[7:0];
        6'd3:  rbyte = 8'd20;
        6'd4:  rbyte = magic_q[31:24];
        6'd5:  rbyte = magic_q[23:16];
        6'd6:  rbyte = magic_q[15:8];
        6'd7:  rbyte = magic_q[7:0];
        6'd20: rbyte = mapattr_q[15:8];
        6'd21: rbyte = mapattr_q[7:0];
        6'd23: rbyte = 8'd8;
        6'd25: rbyte = 8'h01;
        6'd26: rbyte = xport_q[15:8];
        6'd27: rbyte = xport_q[7:0];
        6'd28: rbyte = xip_q[31:24];
        6'd29: rbyte = xip_q[23:16];
        6'd30: rbyte = xip_q[15:8];
        6'd31: rbyte = xip_q[7:0];
        6'd32: rbyte = fpattr_q[15:8];
        6'd33: rbyte = fpattr_q[7:0];
        6'd35: rbyte = 8'd4;
        6'd36: rbyte = fp[31:24];
        6'd37: rbyte = fp[23:16];
        6'd38: rbyte = fp[15:8];
        6'd39: rbyte = fp[7:0];
        default: rbyte = 8'd0;
      endcase
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q;
    crc_in = (cnt_q[2:0] == 3'd0) ? (crc_q ^ {24'd0, rbyte}) : crc_q;
    crc_d = crc_q;
    unique case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
        crc_d = '1;
        if (accept) begin
          if (emit) state_d = ST_PAY;
          else if (final_byte_i && resp_n) state_d = ST_CRC;
          else if (final_byte_i) state_d = ST_STAT;
        end
      end
      ST_PAY: begin
        if (out_ready_i) begin
          if (resp_q) state_d = ST_CRC;
          else if (fin_q) state_d = ST_STAT;
          else state_d = ST_IDLE;
        end
      end
      ST_CRC: begin
        crc_d = crc_in[0] ? ((crc_in >> 1) ^ CRC_POLY) : (crc_in >> 1);
        cnt_d = cnt_q + 8'd1;
        if (cnt_q == CRC_LAST) state_d = ST_RESP;
      end
      ST_RESP: begin
        if (out_ready_i) begin
          cnt_d = cnt_q + 8'd1;
          if (cnt_q[5:0] == RESP_LAST) state_d = ST_STAT;
        end
      end
      ST_STAT: begin
        if (out_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q <= '0;
      crc_q <= '1;
      bp_q <= '0;
      mt_q <= '0;
      ml_q <= '0;
      ak_q <= '0;
      pl_q <= '0;
      cm_q <= 1'b1;
      verdict_q <= STS_PAYLOAD;
      fin_q <= 1'b0;
      resp_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
      crc_q <= crc_d;
      if (accept) begin
        fin_q <= final_byte_i;
        resp_q <= final_byte_i && resp_n;
        if (final_byte_i) begin
          verdict_q <= verdict_n;
          bp_q <= '0;
          mt_q <= '0;
          ml_q <= '0;
          ak_q <= '0;
          pl_q <= '0;
          cm_q <= 1'b1;
        end else begin
          bp_q <= bp_n;
          mt_q <= mt_n;
          ml_q <= ml_n;
          ak_q <= ak_n;
          pl_q <= pl_n;
          cm_q <= cm_n;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pay_byte_q <= data_byte_i;
      count_q <= count_n;
      xport_q <= sender_port_i ^ magic_q[31:16];
      xip_q <= sender_ip_i ^ magic_q;
      if (tid_we) tid_q[tid_wa] <= data_byte_i;
    end
  end

  // outputs
  always_comb begin
    in_ready_o = 1'b0;
    out_valid_o = 1'b0;
    item_kind_o = KIND_PAYLOAD;
    out_byte_o = 8'd0;
    last_of_run_o = 1'b0;
    status_o = STS_PAYLOAD;
    payload_count_o = '0;
    unique case (state_q)
      ST_IDLE: in_ready_o = 1'b1;
      ST_PAY: begin
        out_valid_o = 1'b1;
        out_byte_o = pay_byte_q;
        last_of_run_o = !fin_q;
      end
      ST_CRC: ;
      ST_RESP: begin
        out_valid_o = 1'b1;
        item_kind_o = KIND_RESPONSE;
        out_byte_o = rbyte;
      end
      ST_STAT: begin
        out_valid_o = 1'b1;
        item_kind_o = KIND_STATUS;
        last_of_run_o = 1'b1;
        status_o = verdict_q;
        payload_count_o = count_q;
      end
      default: ;
    endcase
  end

endmodule
